[hdl/shapad_pkg.sv]
// ----------------------------------------------------------------------------
// shapad_pkg
// Types and constants shared by the SHA-256 message padder modules.
// ----------------------------------------------------------------------------
package shapad_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned WORDS_W     = POS_W - 2;
    localparam logic [POS_W-1:0]   LENGTH_POS = POS_W'(56);
    localparam logic [WORDS_W-1:0] LAST_WORD  = '1;
    localparam logic [WORDS_W-1:0] LEN_HI_WORD = LAST_WORD - WORDS_W'(1);
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;
    localparam int unsigned COUNT_W   = 61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        padded_word;
        logic [WORDS_W-1:0] word_index;
        logic               block_end;
        logic               message_end;
    } t_out_item;

    typedef enum logic {
        Q_WORD,
        Q_FINISH
    } t_q_kind;

    // One queue transaction: a finished word, or the end of a message with
    // an optional finished word ahead of the padding.
    typedef struct packed {
        t_q_kind            kind;
        logic               lead;
        logic [31:0]        word;
        logic [WORDS_W-1:0] word_index;
        logic               block_end;
        logic [POS_W-1:0]   pad_pos;
        logic [23:0]        pad_acc;
        logic [63:0]        bit_len;
    } t_q_entry;

    typedef struct packed {
        logic     push;
        t_q_entry entry;
    } t_q_wr;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_rd;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_PAD,
        PH_FILL
    } t_bk_phase;

endpackage

[hdl/sha256_message_padder.sv]
// ----------------------------------------------------------------------------
// sha256_message_padder
// Byte stream in, SHA-256 padded 512-bit blocks out as big-endian words.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-----------------------------
//   in      | i_in_valid  | o_in_stall   | i_in  (data_byte/has_byte/last)
//   out     | o_out_valid | i_out_stall  | o_out (word/index/ends)
//
// One input transaction per cycle while the queue has room; every fourth byte
// gives one output word, which goes through the queue to the output register.
// A last transaction holds the queue head while the back unit emits the
// padding, one word per cycle while the output is not stalled: up to the end
// of the block, or through a second block when the 0x80 lands at byte 56 or
// later (at most 18 words, 19 with the word the last byte completes). The
// input stalls once the queue behind it is full. Output stall holds the
// output register; the queue then fills and stalls the input.  Synchronous
// reset clears counters, queue and sequencer; no sweep.
// ----------------------------------------------------------------------------
module sha256_message_padder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  shapad_pkg::t_in_item  i_in,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output shapad_pkg::t_out_item o_out,
    input  logic                  i_out_stall
);
    import shapad_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    shapad_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    shapad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    shapad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rd      (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

[hdl/shapad_front.sv]
// ----------------------------------------------------------------------------
// shapad_front
// Packs message bytes into words, counts the message length and hands words
// and end-of-message transactions to the queue.
// ----------------------------------------------------------------------------
module shapad_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  shapad_pkg::t_in_item i_in,
    output logic                 o_in_stall,
    input  logic                 i_q_full,
    output shapad_pkg::t_q_wr    o_q_wr
);
    import shapad_pkg::*;

    logic [COUNT_W-1:0] r_total, n_total;
    logic [23:0]        r_acc, n_acc;
    logic [POS_W-1:0]   r_pos, n_pos;

    logic               accept;
    logic [31:0]        byte_word;
    logic [POS_W-1:0]   pos_inc;
    logic               complete;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign byte_word  = {r_acc, i_in.data_byte & BYTE_MASK};
    assign pos_inc    = r_pos + POS_W'(1);
    assign complete   = i_in.has_byte && (pos_inc[1:0] == 2'b00);

    always_comb begin
        n_total = r_total;
        n_acc   = r_acc;
        n_pos   = r_pos;
        o_q_wr  = '0;
        o_q_wr.entry.kind       = Q_WORD;
        o_q_wr.entry.word       = byte_word;
        o_q_wr.entry.word_index = r_pos[POS_W-1:2];
        o_q_wr.entry.block_end  = (pos_inc == '0);
        o_q_wr.entry.lead       = complete;
        if (accept) begin
            if (i_in.has_byte) begin
                n_total = r_total + COUNT_W'(1);
                n_pos   = pos_inc;
                n_acc   = complete ? 24'd0 : byte_word[23:0];
            end
            if (i_in.last) begin
                o_q_wr.push          = 1'b1;
                o_q_wr.entry.kind    = Q_FINISH;
                o_q_wr.entry.pad_pos = n_pos;
                o_q_wr.entry.pad_acc = n_acc;
                o_q_wr.entry.bit_len = {n_total, 3'b000};
                n_total = '0;
                n_acc   = '0;
                n_pos   = '0;
            end else if (complete) begin
                o_q_wr.push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_acc   <= '0;
            r_pos   <= '0;
        end else begin
            r_total <= n_total;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
        end
    end

endmodule

[hdl/shapad_queue.sv]
// ----------------------------------------------------------------------------
// shapad_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module shapad_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shapad_pkg::t_q_wr i_wr,
    output logic              o_full,
    output shapad_pkg::t_q_rd o_rd,
    input  logic              i_pop
);
    import shapad_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign do_push    = i_wr.push && !o_full;
    assign do_pop     = i_pop && (r_count != '0);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wr.entry;
        end
    end

endmodule

[hdl/shapad_back.sv]
// ----------------------------------------------------------------------------
// shapad_back
// Drains the queue into the output register: passes words straight on and
// runs the padding sequence for each end-of-message transaction.
// ----------------------------------------------------------------------------
module shapad_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  shapad_pkg::t_q_rd     i_q_rd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output shapad_pkg::t_out_item o_out,
    input  logic                  i_out_stall
);
    import shapad_pkg::*;

    t_bk_phase          r_phase, n_phase;
    logic [WORDS_W-1:0] r_idx, n_idx;
    logic               r_spill, n_spill;
    logic               r_ov, n_ov;
    t_out_item          r_out, n_out;

    t_q_entry           head;
    logic               load;
    logic               first;
    logic [WORDS_W-1:0] cur_i;
    logic               cur_spill;
    logic [31:0]        pad_word;
    logic [31:0]        fill_word;

    assign head        = i_q_rd.entry;
    assign load        = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    assign first     = (r_phase != PH_FILL);
    assign cur_i     = first ? head.pad_pos[POS_W-1:2] : r_idx;
    assign cur_spill = first ? (head.pad_pos >= LENGTH_POS) : r_spill;

    // 0x80 goes straight after the bytes already held for this word
    always_comb begin
        case (head.pad_pos[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'd0};
            2'd1:    pad_word = {head.pad_acc[7:0], PAD_BYTE, 16'd0};
            2'd2:    pad_word = {head.pad_acc[15:0], PAD_BYTE, 8'd0};
            2'd3:    pad_word = {head.pad_acc[23:0], PAD_BYTE};
            default: pad_word = '0;
        endcase
    end

    always_comb begin
        fill_word = '0;
        if (!cur_spill && cur_i == LEN_HI_WORD) begin
            fill_word = head.bit_len[63:32];
        end else if (!cur_spill && cur_i == LAST_WORD) begin
            fill_word = head.bit_len[31:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_spill = r_spill;
        n_ov    = r_ov;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (load) begin
            n_ov = 1'b0;
        end
        if (load && i_q_rd.valid) begin
            n_ov = 1'b1;
            if (head.kind == Q_WORD) begin
                n_out.padded_word = head.word;
                n_out.word_index  = head.word_index;
                n_out.block_end   = head.block_end;
                n_out.message_end = 1'b0;
                o_pop             = 1'b1;
            end else if (r_phase == PH_HEAD && head.lead) begin
                n_out.padded_word = head.word;
                n_out.word_index  = head.word_index;
                n_out.block_end   = head.block_end;
                n_out.message_end = 1'b0;
                n_phase           = PH_PAD;
            end else begin
                n_out.padded_word = first ? pad_word : fill_word;
                n_out.word_index  = cur_i;
                n_out.block_end   = (cur_i == LAST_WORD);
                n_out.message_end = 1'b0;
                if (cur_i == LAST_WORD) begin
                    if (cur_spill) begin
                        n_idx   = '0;
                        n_spill = 1'b0;
                        n_phase = PH_FILL;
                    end else begin
                        n_out.message_end = 1'b1;
                        o_pop             = 1'b1;
                        n_phase           = PH_HEAD;
                    end
                end else begin
                    n_idx   = cur_i + WORDS_W'(1);
                    n_spill = cur_spill;
                    n_phase = PH_FILL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_idx   <= '0;
            r_spill <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_spill <= n_spill;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SHA-256 message padder. Message bytes go in
// through the valid/stall input channel in random bursts; a byte-level model
// of the padding builds the expected block words. The output channel stalls on
// a changing pattern, and every word is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import shapad_pkg::*;

    localparam int RANDOM_ITEMS  = 160;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 2000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall = 1'b0;

    // padding model state
    logic [COUNT_W-1:0] msg_bytes  = '0;
    logic [23:0]        word_bytes = '0;
    logic [POS_W-1:0]   block_pos  = '0;
    t_out_item          expected_words[$];

    int          fail_count  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_span  = 0;
    int          stall_phase = 0;

    sha256_message_padder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // Appends one byte to the block; every fourth byte completes a word.
    function automatic void shift_in_byte(input logic [7:0] b, input logic closes_msg);
        t_out_item        w;
        logic [POS_W-1:0] pos_next;
        pos_next = block_pos + POS_W'(1);
        if (pos_next[1:0] != 2'b00) begin
            word_bytes = {word_bytes[15:0], b};
        end else begin
            w.padded_word = {word_bytes, b};
            w.word_index  = block_pos[POS_W-1:2];
            w.block_end   = (pos_next == '0);
            w.message_end = closes_msg;
            expected_words.push_back(w);
            word_bytes = '0;
        end
        block_pos = pos_next;
    endfunction

    function automatic void predict_padding(input t_in_item it);
        logic [63:0] bit_len;
        if (it.has_byte) begin
            msg_bytes = msg_bytes + COUNT_W'(1);
            shift_in_byte(it.data_byte, 1'b0);
        end
        if (it.last) begin
            bit_len = {msg_bytes, 3'b000};
            shift_in_byte(PAD_BYTE, 1'b0);
            while (block_pos != LENGTH_POS)
                shift_in_byte(8'h00, 1'b0);
            // length low byte always closes word 15 of the final block
            for (int k = 0; k < 8; k++)
                shift_in_byte(bit_len[63-8*k -: 8], k == 7);
            msg_bytes  = '0;
            word_bytes = '0;
            block_pos  = '0;
        end
    endfunction

    // Prediction on input acceptance, then comparison on output acceptance.
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_padding(i_in);
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, actual %h idx %0d blk_end %b msg_end %b",
                             $time, o_out.padded_word, o_out.word_index,
                             o_out.block_end, o_out.message_end);
                    fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_out.padded_word !== exp_w.padded_word) begin
                        $display("%0t: padded_word expected %h actual %h",
                                 $time, exp_w.padded_word, o_out.padded_word);
                        fail_count++;
                    end
                    if (o_out.word_index !== exp_w.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, exp_w.word_index, o_out.word_index);
                        fail_count++;
                    end
                    if (o_out.block_end !== exp_w.block_end) begin
                        $display("%0t: block_end expected %b actual %b",
                                 $time, exp_w.block_end, o_out.block_end);
                        fail_count++;
                    end
                    if (o_out.message_end !== exp_w.message_end) begin
                        $display("%0t: message_end expected %b actual %b",
                                 $time, exp_w.message_end, o_out.message_end);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Output stall pattern, switched between modes every so often.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_span <= $urandom_range(20, 120);
        end else begin
            stall_span <= stall_span - 1;
        end
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((stall_phase % 5) < 2);
        endcase
    end

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Holds the input idle until every predicted word has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_idle(input logic [7:0] data);
        t_in_item it;
        it.data_byte = data;
        it.has_byte  = 1'b0;
        it.last      = 1'b0;
        send_item(it);
    endtask

    // One message of len random bytes; terminated either on the final byte
    // or by a separate end-only transaction. Idle noise is mixed in.
    task automatic send_message(input int len, input bit end_marker, input int pause_at,
                                output int counted);
        t_in_item it;
        counted = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_idle(8'($urandom));
            if (i == pause_at)
                wait_drained();
            it.data_byte = 8'($urandom);
            it.has_byte  = 1'b1;
            it.last      = (i == len - 1) && !end_marker;
            send_item(it);
            counted++;
        end
        if (end_marker || len == 0) begin
            it.data_byte = 8'($urandom);
            it.has_byte  = 1'b0;
            it.last      = 1'b1;
            send_item(it);
            counted++;
        end
    endtask

    task automatic test_idle_and_empty();
        t_in_item it;
        send_idle(8'hFF);
        send_idle(8'h00);
        it.data_byte = 8'hFF;
        it.has_byte  = 1'b0;
        it.last      = 1'b1;
        send_item(it);
        it.data_byte = 8'h00;
        send_item(it);
        wait_drained();
    endtask

    task automatic test_byte_extremes();
        t_in_item it;
        logic [7:0] seq[9] = '{8'hFF, 8'h00, 8'hFF, 8'h00,
                               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
        // single 0xFF byte with last on the byte
        it = '{data_byte: 8'hFF, has_byte: 1'b1, last: 1'b1};
        send_item(it);
        // three bytes, then end-only transaction carrying junk data
        for (int i = 0; i < 3; i++) begin
            it = '{data_byte: seq[i+1], has_byte: 1'b1, last: 1'b0};
            send_item(it);
        end
        it = '{data_byte: 8'hAA, has_byte: 1'b0, last: 1'b1};
        send_item(it);
        // exactly one word of 0xFF, last on the word boundary
        for (int i = 4; i < 8; i++) begin
            it = '{data_byte: seq[i], has_byte: 1'b1, last: (i == 7)};
            send_item(it);
        end
        // idle between bytes must not disturb the word in progress
        it = '{data_byte: seq[8], has_byte: 1'b1, last: 1'b0};
        send_item(it);
        send_idle(8'h55);
        it = '{data_byte: 8'h7F, has_byte: 1'b1, last: 1'b1};
        send_item(it);
        wait_drained();
    endtask

    // 0x80 landing at bytes 55, 56, 63 and 0 of a block; 56 and 63 spill
    // the length into a second block.
    task automatic test_length_boundaries();
        int lens[4] = '{55, 56, 63, 64};
        int counted;
        for (int i = 0; i < 4; i++)
            send_message(lens[i], i[0], -1, counted);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        int sel;
        int pause_at;
        int counted;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(0, 9);
            else if (sel < 92)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(120, 135);
            pause_at = ($urandom_range(0, 7) == 0 && len > 0) ? $urandom_range(0, len - 1) : -1;
            send_message(len, $urandom_range(0, 1), pause_at, counted);
            sent += counted;
        end
        wait_drained();
    endtask

    // The 2^64-bit length wrap cannot be reached within a simulation run.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_and_empty();
        test_byte_extremes();
        test_length_boundaries();
        test_random_messages();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
